### hdl/transposition_table_probe_store_assert.svh
// assertion macros for the transposition table probe store block
// used by modules that check their own control logic
`ifndef TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH
`define TRANSPOSITION_TABLE_PROBE_STORE_ASSERT_SVH

// checked outside reset only
`define TTPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define TTPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/ttps_pkg.sv
// shared types and constants of the transposition table probe store block
// no dependencies
package ttps_pkg;

    // request function codes
    localparam logic [1:0] FuncProbe = 2'd0;
    localparam logic [1:0] FuncStore = 2'd1;
    localparam logic [1:0] FuncClear = 2'd2;

    // bound kinds
    localparam logic [1:0] BoundExact = 2'd0;
    localparam logic [1:0] BoundUpper = 2'd1;
    localparam logic [1:0] BoundLower = 2'd2;

    localparam int unsigned MaxSearchDepth  = 63;
    localparam logic [30:0] MateLimitReset  = 31'd99936;
    localparam int unsigned CmdQueueDepth   = 2;

    typedef enum logic [1:0] {
        OP_PROBE,
        OP_STORE,
        OP_CLEAR
    } t_op;

    // one classified command between the front and the back
    typedef struct packed {
        t_op         op;
        logic [63:0] key;
        logic [5:0]  depth;
        logic [31:0] alpha;
        logic [31:0] beta;
        logic [31:0] score;
        logic [1:0]  bound;
        logic [31:0] move;
    } t_cmd;

    typedef struct packed {
        logic sweeping;
    } t_back_status;

endpackage

### hdl/ttps_if.sv
// channel interfaces of the transposition table probe store block
// no dependencies
interface ttps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] key;
    logic [5:0]  depth;
    logic signed [31:0] alpha;
    logic signed [31:0] beta;
    logic signed [31:0] score;
    logic [1:0]  bound_kind;
    logic [31:0] store_move;

    modport source(output valid, func, key, depth, alpha, beta, score, bound_kind,
                   store_move, input ready);
    modport sink(input valid, func, key, depth, alpha, beta, score, bound_kind,
                 store_move, output ready);
endinterface

interface ttps_out_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] found_move;
    logic        settled;
    logic signed [31:0] settled_score;

    modport source(output valid, hit, found_move, settled, settled_score, input ready);
    modport sink(input valid, hit, found_move, settled, settled_score, output ready);
endinterface

interface ttps_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] mate_limit;

    modport source(output valid, mate_limit, input ready);
    modport sink(input valid, mate_limit, output ready);
endinterface

### hdl/transposition_table_probe_store.sv
// top level of the transposition table probe store block
// depends on ttps_pkg, ttps_if, ttps_cmd_fifo, ttps_front and ttps_back
//
// Usage:
//   i_req carries probe, store and clear requests; o_rsp returns one result per
//   probe (hit, found move, settled flag and score); stores, clears, unused
//   function codes and stores of mate scores give no result.
//   i_cfg writes the mate limit; i_cfg.ready is always high and writes are
//   expected while the block is idle.
//   A probe result passes through the command queue, the probe stage and the
//   result register. Probes and stores are taken one per cycle unless the
//   command queue is full or a sweep runs; the table has one memory port, and
//   a probe reads it once, a store writes it once. A clear walks the table one
//   entry per cycle, and no request is taken until it has cleared every entry.
//   Reset runs the same sweep before the first request is taken.
//   When o_rsp stalls, the result register holds, one more probe waits in the
//   probe stage and the command queue fills; stores and clears keep flowing
//   until a probe reaches the full probe stage.
//   TABLE_ENTRIES must be a power of two; the low key bits select the entry.
module transposition_table_probe_store #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MOVE_BITS     = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttps_in_if.sink    i_req,
    ttps_cfg_if.sink   i_cfg,
    ttps_out_if.source o_rsp
);
    ttps_pkg::t_cmd push_cmd, head_cmd;
    ttps_pkg::t_back_status back_status;
    logic push, pop, queue_full, head_valid;

    ttps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_cfg        (i_cfg),
        .i_back_status(back_status),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_push_cmd   (push_cmd)
    );

    ttps_cmd_fifo u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_cmd(push_cmd),
        .o_full    (queue_full),
        .i_pop     (pop),
        .o_valid   (head_valid),
        .o_head    (head_cmd)
    );

    ttps_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MOVE_BITS    (MOVE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(head_valid),
        .i_cmd      (head_cmd),
        .o_cmd_pop  (pop),
        .o_status   (back_status),
        .o_rsp      (o_rsp)
    );
endmodule

### hdl/ttps_cmd_fifo.sv
// short command queue between the front and the back
// depends on ttps_pkg
module ttps_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttps_pkg::t_cmd i_push_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ttps_pkg::t_cmd o_head
);
    localparam int PtrBits = $clog2(ttps_pkg::CmdQueueDepth);
    localparam int CntBits = $clog2(ttps_pkg::CmdQueueDepth + 1);

    ttps_pkg::t_cmd r_slot [ttps_pkg::CmdQueueDepth];
    logic [PtrBits-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntBits-1:0] r_count;

    assign o_full  = (r_count == CntBits'(ttps_pkg::CmdQueueDepth));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrBits'(ttps_pkg::CmdQueueDepth - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrBits'(ttps_pkg::CmdQueueDepth - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end
endmodule

### hdl/ttps_front.sv
// front end: takes requests and config writes, classifies and filters them
// depends on ttps_pkg and the channel interfaces
module ttps_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ttps_in_if.sink              i_req,
    ttps_cfg_if.sink             i_cfg,
    input  ttps_pkg::t_back_status i_back_status,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output ttps_pkg::t_cmd       o_push_cmd
);
    logic [30:0] r_mate_limit;
    logic signed [32:0] score_x, lim_x, neg_lim;
    logic is_mate;
    logic [5:0] sat_depth;
    logic accept;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !i_queue_full && !i_back_status.sweeping;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mate_limit <= ttps_pkg::MateLimitReset;
        end else if (i_cfg.valid) begin
            r_mate_limit <= i_cfg.mate_limit;
        end
    end

    always_comb begin
        score_x = {i_req.score[31], i_req.score};
        lim_x   = {2'b00, r_mate_limit};
        neg_lim = -lim_x;
        is_mate = (score_x > lim_x) || (score_x < neg_lim);
        sat_depth = ({2'b00, i_req.depth} > 8'(ttps_pkg::MaxSearchDepth)) ?
                    6'(ttps_pkg::MaxSearchDepth) : i_req.depth;
    end

    always_comb begin
        o_push_cmd.op    = ttps_pkg::OP_PROBE;
        o_push_cmd.key   = i_req.key;
        o_push_cmd.depth = i_req.depth;
        o_push_cmd.alpha = i_req.alpha;
        o_push_cmd.beta  = i_req.beta;
        o_push_cmd.score = i_req.score;
        o_push_cmd.bound = i_req.bound_kind;
        o_push_cmd.move  = i_req.store_move;
        o_push = 1'b0;
        unique case (i_req.func)
            ttps_pkg::FuncProbe: begin
                o_push = accept;
            end
            ttps_pkg::FuncStore: begin
                // mate scores never reach the table
                o_push_cmd.op    = ttps_pkg::OP_STORE;
                o_push_cmd.depth = sat_depth;
                o_push = accept && !is_mate;
            end
            ttps_pkg::FuncClear: begin
                o_push_cmd.op = ttps_pkg::OP_CLEAR;
                o_push = accept;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end
endmodule

### hdl/ttps_back.sv
// back end: table memory, clearing sweep, probe evaluation and result register
// depends on ttps_pkg, the channel interfaces and the assertion macros
`include "transposition_table_probe_store_assert.svh"

module ttps_back #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int MOVE_BITS     = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  ttps_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_pop,
    output ttps_pkg::t_back_status o_status,
    ttps_out_if.source            o_rsp
);
    localparam int IndexBits = $clog2(TABLE_ENTRIES);

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    // table memory
    logic [63:0]          r_mem_key   [TABLE_ENTRIES];
    logic [5:0]           r_mem_depth [TABLE_ENTRIES];
    logic [31:0]          r_mem_score [TABLE_ENTRIES];
    logic [1:0]           r_mem_bound [TABLE_ENTRIES];
    logic [MOVE_BITS-1:0] r_mem_move  [TABLE_ENTRIES];

    t_state r_state, n_state;
    logic [IndexBits-1:0] r_sweep_idx, n_sweep_idx;

    // probe stage: request fields and registered read data
    logic        r_p_valid;
    logic [63:0] r_p_key;
    logic [5:0]  r_p_depth;
    logic [31:0] r_p_alpha, r_p_beta;
    logic [63:0] r_rd_key;
    logic [5:0]  r_rd_depth;
    logic [31:0] r_rd_score;
    logic [1:0]  r_rd_bound;
    logic [MOVE_BITS-1:0] r_rd_move;

    // result register
    logic        r_o_valid;
    logic        r_o_hit, r_o_settled;
    logic [31:0] r_o_move, r_o_score;

    logic [IndexBits-1:0] cmd_idx, mem_addr;
    logic mem_we, sweeping, adv, p_free, pop_probe, pop_store, pop_clear;
    logic hit, deep, settle;
    logic [31:0] settle_val;

    assign sweeping   = (r_state == ST_SWEEP);
    assign cmd_idx    = i_cmd.key[IndexBits-1:0];
    assign adv        = r_p_valid && (!r_o_valid || o_rsp.ready);
    assign p_free     = !r_p_valid || adv;
    assign o_cmd_pop  = !sweeping && i_cmd_valid &&
                        ((i_cmd.op != ttps_pkg::OP_PROBE) || p_free);
    assign pop_probe  = o_cmd_pop && (i_cmd.op == ttps_pkg::OP_PROBE);
    assign pop_store  = o_cmd_pop && (i_cmd.op == ttps_pkg::OP_STORE);
    assign pop_clear  = o_cmd_pop && (i_cmd.op == ttps_pkg::OP_CLEAR);
    assign mem_we     = sweeping || pop_store;
    assign mem_addr   = sweeping ? r_sweep_idx : cmd_idx;
    assign o_status.sweeping = sweeping;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_key[mem_addr]   <= sweeping ? '0 : i_cmd.key;
            r_mem_depth[mem_addr] <= sweeping ? '0 : i_cmd.depth;
            r_mem_score[mem_addr] <= sweeping ? '0 : i_cmd.score;
            r_mem_bound[mem_addr] <= sweeping ? ttps_pkg::BoundExact : i_cmd.bound;
            r_mem_move[mem_addr]  <= sweeping ? '0 : i_cmd.move[MOVE_BITS-1:0];
        end
        if (pop_probe) begin
            r_rd_key   <= r_mem_key[cmd_idx];
            r_rd_depth <= r_mem_depth[cmd_idx];
            r_rd_score <= r_mem_score[cmd_idx];
            r_rd_bound <= r_mem_bound[cmd_idx];
            r_rd_move  <= r_mem_move[cmd_idx];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sweep_idx = r_sweep_idx;
        unique case (r_state)
            ST_SWEEP: begin
                n_sweep_idx = r_sweep_idx + 1'b1;
                if (&r_sweep_idx) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (pop_clear) begin
                    n_state     = ST_SWEEP;
                    n_sweep_idx = '0;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    // cutoff decision on the registered entry
    always_comb begin
        hit        = (r_rd_key == r_p_key);
        deep       = (r_rd_depth >= r_p_depth);
        settle     = 1'b0;
        settle_val = '0;
        if (hit && deep) begin
            case (r_rd_bound)
                ttps_pkg::BoundExact: begin
                    settle     = 1'b1;
                    settle_val = r_rd_score;
                end
                ttps_pkg::BoundUpper: begin
                    if ($signed(r_rd_score) <= $signed(r_p_alpha)) begin
                        settle     = 1'b1;
                        settle_val = r_p_alpha;
                    end
                end
                ttps_pkg::BoundLower: begin
                    if ($signed(r_rd_score) >= $signed(r_p_beta)) begin
                        settle     = 1'b1;
                        settle_val = r_p_beta;
                    end
                end
                default: begin
                    settle = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_sweep_idx <= '0;
            r_p_valid   <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep_idx <= n_sweep_idx;
            if (pop_probe) begin
                r_p_valid <= 1'b1;
                r_p_key   <= i_cmd.key;
                r_p_depth <= i_cmd.depth;
                r_p_alpha <= i_cmd.alpha;
                r_p_beta  <= i_cmd.beta;
            end else if (adv) begin
                r_p_valid <= 1'b0;
            end
            if (adv) begin
                r_o_valid   <= 1'b1;
                r_o_hit     <= hit;
                r_o_move    <= hit ? 32'(r_rd_move) : '0;
                r_o_settled <= settle;
                r_o_score   <= settle_val;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.hit           = r_o_hit;
    assign o_rsp.found_move    = r_o_move;
    assign o_rsp.settled       = r_o_settled;
    assign o_rsp.settled_score = r_o_score;

    `TTPS_ASSERT(a_no_cmd_in_sweep, i_clk, i_rst_n, sweeping |-> !o_cmd_pop, "command taken during sweep")
    `TTPS_ASSERT(a_clear_starts_sweep, i_clk, i_rst_n, pop_clear |=> (sweeping && r_sweep_idx == '0), "clear did not start sweep")
    `TTPS_ASSERT(a_sweep_runs_out, i_clk, i_rst_n, (sweeping && !(&r_sweep_idx)) |=> sweeping, "sweep ended early")
    `TTPS_ASSERT(a_probe_held, i_clk, i_rst_n, (r_p_valid && !adv) |=> (r_p_valid && $stable(r_p_key)), "stalled probe lost")
endmodule
